/* hdl/cfop_pkg.sv */
// Shared constants, types and helper functions for the camera follow offset pose block.
package cfop_pkg;

  // Default number of CORDIC micro-rotations
  localparam int unsigned CORDIC_STEPS_DEF = 16;
  localparam int unsigned CORDIC_STEPS_MAX = 24;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_VIEW_HEADING  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VIEW_PITCH    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VIEW_DISTANCE = 2'd2;
  localparam int unsigned CFG_DATA_W = 24;

  // Register reset values
  localparam logic signed [15:0] VIEW_HEADING_RST  = 16'sd8579;
  localparam logic signed [15:0] VIEW_PITCH_RST    = 16'sd6434;
  localparam logic [23:0]        VIEW_DISTANCE_RST = 24'd327680;

  // Angles in Q2.13, held at 18 bits for sums of two 16 bit angles plus pi
  localparam logic signed [17:0] ANG_PI      = 18'sd25736;
  localparam logic signed [17:0] ANG_TWO_PI  = 18'sd51472;
  localparam logic signed [17:0] ANG_HALF_PI = 18'sd12868;

  // CORDIC start vector (gain compensation, Q30)
  localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;

  // Arctangent of 2^-i, Q30, truncated
  localparam logic [29:0] ATAN_Q30 [CORDIC_STEPS_MAX] = '{
    30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158,
    30'd67021686,  30'd33543515,  30'd16775850,  30'd8388437,
    30'd4194282,   30'd2097149,   30'd1048575,   30'd524287,
    30'd262143,    30'd131071,    30'd65535,     30'd32767,
    30'd16383,     30'd8191,      30'd4095,      30'd2047,
    30'd1023,      30'd511,       30'd255,       30'd127
  };

  // Folded angle handed to the CORDIC
  typedef struct packed {
    logic              neg;
    logic signed [31:0] z;
  } fold_t;

  // Sideband that rides along the pipeline with each transaction
  typedef struct packed {
    logic signed [31:0] tx;
    logic signed [31:0] ty;
    logic signed [31:0] tz;
    logic signed [15:0] yaw;
    logic [31:0]        dur;
    logic               last;
    logic               hneg;
    logic               pneg;
  } side_t;

  // Wrap once into [-pi, pi], fold into [-pi/2, pi/2], scale Q2.13 to Q30
  function automatic fold_t fold_angle(input logic signed [16:0] a);
    logic signed [17:0] w;
    fold_t r;
    w = {a[16], a};
    if (w > ANG_PI) begin
      w = w - ANG_TWO_PI;
    end else if (w < -ANG_PI) begin
      w = w + ANG_TWO_PI;
    end
    r.neg = 1'b0;
    if (w > ANG_HALF_PI) begin
      w = w - ANG_PI;
      r.neg = 1'b1;
    end else if (w < -ANG_HALF_PI) begin
      w = w + ANG_PI;
      r.neg = 1'b1;
    end
    // |w| <= pi/2 fits 15 bits signed
    r.z = {w[14:0], 17'd0};
    return r;
  endfunction

  // Camera yaw: yaw + pi + heading, one 2*pi wrap, clamp to 16 bits
  function automatic logic signed [15:0] cam_yaw_calc(input logic signed [15:0] yaw,
                                                      input logic signed [15:0] hdg);
    logic signed [17:0] s;
    logic signed [15:0] r;
    s = {{2{yaw[15]}}, yaw} + ANG_PI + {{2{hdg[15]}}, hdg};
    if (s > ANG_PI) begin
      s = s - ANG_TWO_PI;
    end
    if (s > 18'sd32767) begin
      r = 16'sh7FFF;
    end else if (s < -18'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = s[15:0];
    end
    return r;
  endfunction

  // Clamp a 33 bit sum to the signed 32 bit range
  function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
    logic signed [31:0] r;
    if (v[32] != v[31]) begin
      r = v[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

/* hdl/camera_follow_offset_pose.sv */
// Camera follow offset pose: camera position and yaw for one target pose point.
//
// Usage:
//   Input: present target_x/y/z, target_yaw, step_time and last_point with
//   start high; the transaction is taken at a rising edge where busy is low.
//   busy is high only during and right after reset, so one point can enter
//   every cycle.
//   Output: each result shows on cam_* for exactly one cycle with done high.
//   done is registered together with cam_* in the final add/saturate stage.
//   The path is one entry stage (angle wrap and fold), CORDIC_STEPS stages of
//   two parallel CORDICs (heading + yaw, and pitch), a sign stage, a distance
//   multiply stage, a rotation multiply stage and a final add/saturate stage.
//   Throughput: one point per cycle, results in input order.
//   Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; ready is
//   always high. Write only while no point is in flight.
//   Reset (rst, synchronous) empties the pipeline and restores the registers
//   to heading pi/3, pitch pi/4, distance 5 m.
//   The receiver cannot stall: results are never held or repeated.
module camera_follow_offset_pose #(
  parameter int unsigned CORDIC_STEPS = cfop_pkg::CORDIC_STEPS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // configuration write channel
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [cfop_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cfop_pkg::CFG_DATA_W-1:0] cfg_data,
  // command input
  input  logic                           start,
  output logic                           busy,
  input  logic signed [31:0]             target_x,
  input  logic signed [31:0]             target_y,
  input  logic signed [31:0]             target_z,
  input  logic signed [15:0]             target_yaw,
  input  logic [31:0]                    step_time,
  input  logic                           last_point,
  // result output
  output logic                           done,
  output logic signed [31:0]             cam_x,
  output logic signed [31:0]             cam_y,
  output logic signed [31:0]             cam_z,
  output logic signed [15:0]             cam_yaw,
  output logic [31:0]                    cam_time,
  output logic                           cam_last
);
  import cfop_pkg::*;

  localparam int unsigned N = CORDIC_STEPS;
  localparam logic signed [56:0] RND57 = 57'sd1 <<< 29;
  localparam logic signed [57:0] RND58 = 58'sd1 <<< 29;

  // configuration registers
  logic signed [15:0] view_heading;
  logic signed [15:0] view_pitch;
  logic [23:0]        view_distance;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      view_heading  <= VIEW_HEADING_RST;
      view_pitch    <= VIEW_PITCH_RST;
      view_distance <= VIEW_DISTANCE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_VIEW_HEADING:  view_heading  <= cfg_data[15:0];
        REG_VIEW_PITCH:    view_pitch    <= cfg_data[15:0];
        REG_VIEW_DISTANCE: view_distance <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  // busy only covers reset
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
    end else begin
      busy <= 1'b0;
    end
  end

  // pipeline storage
  logic [N:0]         vld;
  logic signed [31:0] hx [N+1];
  logic signed [31:0] hy [N+1];
  logic signed [31:0] hz [N+1];
  logic signed [31:0] px [N+1];
  logic signed [31:0] py [N+1];
  logic signed [31:0] pz [N+1];
  side_t              side [N+1];

  // entry stage: angle sums, wrap and fold
  logic signed [16:0] head_sum;
  fold_t              head_fold;
  fold_t              pitch_fold;
  side_t              side_in;

  always_comb begin
    head_sum     = {view_heading[15], view_heading} + {target_yaw[15], target_yaw};
    head_fold    = fold_angle(head_sum);
    pitch_fold   = fold_angle({view_pitch[15], view_pitch});
    side_in.tx   = target_x;
    side_in.ty   = target_y;
    side_in.tz   = target_z;
    side_in.yaw  = cam_yaw_calc(target_yaw, view_heading);
    side_in.dur  = step_time;
    side_in.last = last_point;
    side_in.hneg = head_fold.neg;
    side_in.pneg = pitch_fold.neg;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= start && !busy;
    end
    hx[0]   <= CORDIC_GAIN;
    hy[0]   <= '0;
    hz[0]   <= head_fold.z;
    px[0]   <= CORDIC_GAIN;
    py[0]   <= '0;
    pz[0]   <= pitch_fold.z;
    side[0] <= side_in;
  end

  // CORDIC micro-rotations, one per stage, both angles side by side
  for (genvar i = 0; i < N; i++) begin : g_cordic
    localparam logic signed [31:0] ATAN_I = {2'b00, ATAN_Q30[i]};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else begin
        vld[i+1] <= vld[i];
      end
      if (hz[i][31]) begin
        hx[i+1] <= hx[i] + (hy[i] >>> i);
        hy[i+1] <= hy[i] - (hx[i] >>> i);
        hz[i+1] <= hz[i] + ATAN_I;
      end else begin
        hx[i+1] <= hx[i] - (hy[i] >>> i);
        hy[i+1] <= hy[i] + (hx[i] >>> i);
        hz[i+1] <= hz[i] - ATAN_I;
      end
      if (pz[i][31]) begin
        px[i+1] <= px[i] + (py[i] >>> i);
        py[i+1] <= py[i] - (px[i] >>> i);
        pz[i+1] <= pz[i] + ATAN_I;
      end else begin
        px[i+1] <= px[i] - (py[i] >>> i);
        py[i+1] <= py[i] + (px[i] >>> i);
        pz[i+1] <= pz[i] - ATAN_I;
      end
      side[i+1] <= side[i];
    end
  end

  // sign stage: undo the fold by pi
  logic               m1_vld;
  logic signed [31:0] m1_hc, m1_hs, m1_pc, m1_ps;
  side_t              m1_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_vld <= 1'b0;
    end else begin
      m1_vld <= vld[N];
    end
    m1_hc   <= side[N].hneg ? -hx[N] : hx[N];
    m1_hs   <= side[N].hneg ? -hy[N] : hy[N];
    m1_pc   <= side[N].pneg ? -px[N] : px[N];
    m1_ps   <= side[N].pneg ? -py[N] : py[N];
    m1_side <= side[N];
  end

  // distance stage: horizontal and vertical offsets, rounded to Q16.16
  logic signed [24:0] dist_s;
  logic signed [56:0] horiz_prod, height_prod;
  logic               m2_vld;
  logic signed [25:0] m2_horiz, m2_height;
  logic signed [31:0] m2_hc, m2_hs;
  side_t              m2_side;

  always_comb begin
    dist_s      = {1'b0, view_distance};
    horiz_prod  = m1_pc * dist_s + RND57;
    height_prod = m1_ps * dist_s + RND57;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m2_vld <= 1'b0;
    end else begin
      m2_vld <= m1_vld;
    end
    m2_horiz  <= horiz_prod[55:30];
    m2_height <= height_prod[55:30];
    m2_hc     <= m1_hc;
    m2_hs     <= m1_hs;
    m2_side   <= m1_side;
  end

  // rotation stage: horizontal offset turned by heading + yaw; z done here
  logic signed [57:0] offx_prod, offy_prod;
  logic signed [32:0] z_sum;
  logic               m3_vld;
  logic signed [26:0] m3_offx, m3_offy;
  logic signed [31:0] m3_z;
  side_t              m3_side;

  always_comb begin
    offx_prod = m2_hc * m2_horiz + RND58;
    offy_prod = m2_hs * m2_horiz + RND58;
    z_sum     = {m2_side.tz[31], m2_side.tz} - {{7{m2_height[25]}}, m2_height};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m3_vld <= 1'b0;
    end else begin
      m3_vld <= m2_vld;
    end
    m3_offx <= offx_prod[56:30];
    m3_offy <= offy_prod[56:30];
    m3_z    <= sat32(z_sum);
    m3_side <= m2_side;
  end

  // output stage: add to target, saturate
  logic signed [32:0] x_sum, y_sum;

  always_comb begin
    x_sum = {m3_side.tx[31], m3_side.tx} + {{6{m3_offx[26]}}, m3_offx};
    y_sum = {m3_side.ty[31], m3_side.ty} + {{6{m3_offy[26]}}, m3_offy};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= m3_vld;
    end
    cam_x    <= sat32(x_sum);
    cam_y    <= sat32(y_sum);
    cam_z    <= m3_z;
    cam_yaw  <= m3_side.yaw;
    cam_time <= m3_side.dur;
    cam_last <= m3_side.last;
  end

endmodule

/* hdl/cfop_checker.sv */
// Port-level checker for the camera follow offset pose block, with its bind.
module cfop_checker #(
  parameter int unsigned CORDIC_STEPS = cfop_pkg::CORDIC_STEPS_DEF
) (
  input logic                           clk,
  input logic                           rst,
  input logic                           start,
  input logic                           busy,
  input logic [31:0]                    step_time,
  input logic                           last_point,
  input logic                           done,
  input logic [31:0]                    cam_time,
  input logic                           cam_last
);
  import cfop_pkg::*;

  // edges from accepting a transaction to sampling its result
  localparam int unsigned LAT = CORDIC_STEPS + 5;

  // ready for commands in the cycle after reset drops
  a_busy_clear: assert property (@(posedge clk) !rst |=> !busy)
    else $error("busy still high after reset released");

  // reset empties the pipeline
  a_reset_flush: assert property (@(posedge clk) rst |=> !done)
    else $error("result strobe right after reset");

  // every accepted transaction yields a result at fixed latency
  a_latency: assert property (@(posedge clk) disable iff (rst)
      (start && !busy) |-> ##LAT done)
    else $error("result missing at expected latency");

  // no result without a matching transaction
  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
      done |-> $past(start && !busy, LAT))
    else $error("result without accepted transaction");

  // duration and last mark travel with their own point
  a_passthrough: assert property (@(posedge clk) disable iff (rst)
      done |-> (cam_time == $past(step_time, LAT)) && (cam_last == $past(last_point, LAT)))
    else $error("sideband fields out of step with position");

endmodule

bind camera_follow_offset_pose cfop_checker #(.CORDIC_STEPS(CORDIC_STEPS)) u_cfop_checker (.*);

/* tb/sv/camera_follow_offset_pose_tb.sv */
// Self-checking testbench for the camera follow offset pose block.
module camera_follow_offset_pose_tb;
  import cfop_pkg::*;

  localparam int STEPS     = 16;
  localparam int LATENCY   = STEPS + 5;
  localparam int ANGLE_PI  = 25736;
  localparam int ANGLE_2PI = 51472;
  localparam int ANGLE_PI2 = 12868;
  localparam longint START_X = 652032874;
  localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;
  localparam int PHASES = 8;
  localparam int PHASE_POINTS = 92;

  // arctangent of 2^-i, Q30, truncated
  localparam longint ATAN_TAB [STEPS] = '{
    843314856, 497837829, 263043836, 133525158,
    67021686,  33543515,  16775850,  8388437,
    4194282,   2097149,   1048575,   524287,
    262143,    131071,    65535,     32767
  };

  typedef struct packed {
    logic signed [31:0] x, y, z;
    logic signed [15:0] yaw;
    logic [31:0]        dur;
    logic               last;
  } target_pt_t;

  typedef struct packed {
    logic signed [31:0] x, y, z;
    logic signed [15:0] yaw;
    logic [31:0]        dur;
    logic               last;
  } cam_pose_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic start = 1'b0;
  logic busy;
  target_pt_t drv_pt = '0;
  logic done;
  logic signed [31:0] cam_x, cam_y, cam_z;
  logic signed [15:0] cam_yaw;
  logic [31:0] cam_time;
  logic cam_last;

  // shadow copy of the view registers
  logic signed [15:0] heading_q = 16'sd8579;
  logic signed [15:0] pitch_q = 16'sd6434;
  logic [23:0] distance_q = 24'd327680;

  target_pt_t pending_points[$];
  cam_pose_t expected_poses[$];
  int points_queued = 0;
  int points_sent = 0;
  int idle_pct = 12;
  int errors = 0;
  logic point_taken = 1'b0;
  logic cfg_taken = 1'b0;

  camera_follow_offset_pose #(.CORDIC_STEPS(STEPS)) u_dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .start(start), .busy(busy),
    .target_x(drv_pt.x), .target_y(drv_pt.y), .target_z(drv_pt.z),
    .target_yaw(drv_pt.yaw), .step_time(drv_pt.dur), .last_point(drv_pt.last),
    .done(done),
    .cam_x(cam_x), .cam_y(cam_y), .cam_z(cam_z),
    .cam_yaw(cam_yaw), .cam_time(cam_time), .cam_last(cam_last)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // round a Q30 by Q16.16 product to Q16.16, ties up
  function automatic longint mul_q30(input longint a, input longint b);
    return (a * b + (longint'(1) <<< 29)) >>> 30;
  endfunction

  function automatic logic signed [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  // cosine and sine in Q30: one 2*pi wrap, fold to +-pi/2, rotation CORDIC
  function automatic void cordic_sin_cos(input int ang, output longint c, output longint s);
    longint x, y, z, nx;
    int a;
    bit flip;
    a = ang;
    x = START_X;
    y = 0;
    flip = 1'b0;
    if (a > ANGLE_PI) a -= ANGLE_2PI;
    else if (a < -ANGLE_PI) a += ANGLE_2PI;
    if (a > ANGLE_PI2) begin
      a -= ANGLE_PI;
      flip = 1'b1;
    end else if (a < -ANGLE_PI2) begin
      a += ANGLE_PI;
      flip = 1'b1;
    end
    z = longint'(a) * 131072;
    for (int i = 0; i < STEPS; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z -= ATAN_TAB[i];
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z += ATAN_TAB[i];
      end
      x = nx;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  // camera pose for one target point under the current view registers
  function automatic cam_pose_t predict_pose(input target_pt_t p);
    longint pc, ps, hc, hs, horiz, height;
    int cy;
    cam_pose_t r;
    cordic_sin_cos(int'(pitch_q), pc, ps);
    horiz = mul_q30(pc, longint'(distance_q));
    height = mul_q30(ps, longint'(distance_q));
    cordic_sin_cos(int'(heading_q) + int'($signed(p.yaw)), hc, hs);
    cy = int'($signed(p.yaw)) + ANGLE_PI + int'(heading_q);
    if (cy > ANGLE_PI) cy -= ANGLE_2PI;
    if (cy > 32767) cy = 32767;
    else if (cy < -32768) cy = -32768;
    r.x = clamp32(longint'($signed(p.x)) + mul_q30(hc, horiz));
    r.y = clamp32(longint'($signed(p.y)) + mul_q30(hs, horiz));
    r.z = clamp32(longint'($signed(p.z)) - height);
    r.yaw = cy[15:0];
    r.dur = p.dur;
    r.last = p.last;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR t=%0t %s", $time, msg);
    errors++;
  endtask

  // result check, then prediction of the transaction taken at this edge
  always @(posedge clk) begin
    cam_pose_t want;
    if (rst) begin
      heading_q <= 16'sd8579;
      pitch_q <= 16'sd6434;
      distance_q <= 24'd327680;
      point_taken <= 1'b0;
      cfg_taken <= 1'b0;
    end else begin
      if (done === 1'b1) begin
        if (expected_poses.size() == 0) begin
          report_mismatch("result with no transaction pending");
        end else begin
          want = expected_poses.pop_front();
          if (cam_x !== want.x)
            report_mismatch($sformatf("cam_x %0d expected %0d", cam_x, want.x));
          if (cam_y !== want.y)
            report_mismatch($sformatf("cam_y %0d expected %0d", cam_y, want.y));
          if (cam_z !== want.z)
            report_mismatch($sformatf("cam_z %0d expected %0d", cam_z, want.z));
          if (cam_yaw !== want.yaw)
            report_mismatch($sformatf("cam_yaw %0d expected %0d", cam_yaw, want.yaw));
          if (cam_time !== want.dur)
            report_mismatch($sformatf("cam_time %h expected %h", cam_time, want.dur));
          if (cam_last !== want.last)
            report_mismatch($sformatf("cam_last %b expected %b", cam_last, want.last));
        end
      end
      if (start && !busy) begin
        expected_poses.insert(expected_poses.size(), predict_pose(drv_pt));
        points_sent <= points_sent + 1;
      end
      point_taken <= start && !busy;
      cfg_taken <= cfg_valid && cfg_ready;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_VIEW_HEADING:  heading_q <= cfg_data[15:0];
          REG_VIEW_PITCH:    pitch_q <= cfg_data[15:0];
          REG_VIEW_DISTANCE: distance_q <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // driver: present the next point once the current one is taken
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || point_taken) begin
      if (pending_points.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
        drv_pt <= pending_points.pop_front();
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  task automatic add_point(input logic signed [31:0] x, input logic signed [31:0] y,
                           input logic signed [31:0] z, input logic signed [15:0] yaw,
                           input logic [31:0] dur, input logic last);
    target_pt_t p;
    p.x = x;
    p.y = y;
    p.z = z;
    p.yaw = yaw;
    p.dur = dur;
    p.last = last;
    pending_points.insert(pending_points.size(), p);
    points_queued++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(negedge clk); while (!cfg_taken);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    while (points_sent != points_queued || expected_poses.size() != 0) @(negedge clk);
  endtask

  // positions: full range, near zero, or close to either rail
  function automatic logic signed [31:0] rand_pos();
    logic signed [31:0] v;
    case ($urandom_range(0, 3))
      0: v = $urandom;
      1: v = $urandom_range(0, 33554432) - 32'd16777216;
      2: v = 32'h7FFF_FFFF - $urandom_range(0, 33554432);
      default: v = 32'h8000_0000 + $urandom_range(0, 33554432);
    endcase
    return v;
  endfunction

  // yaw mostly within +-pi, sometimes any bit pattern
  function automatic logic signed [15:0] rand_yaw();
    logic [31:0] v;
    if ($urandom_range(0, 4) == 0) v = $urandom;
    else v = $urandom_range(0, ANGLE_2PI) - ANGLE_PI;
    return v[15:0];
  endfunction

  // stimulus sequencing
  initial begin
    int hdg, pit;
    logic [31:0] word;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // directed points under reset view settings
    add_point(32'sd0, 32'sd0, 32'sd0, 16'sd0, 32'h0, 1'b0);
    add_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 16'sd25736, 32'hFFFF_FFFF, 1'b1);
    add_point(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, -16'sd25736, 32'h0, 1'b0);
    add_point(32'sh0001_0000, -32'sh0001_0000, 32'sh0002_0000, 16'sd12868, 32'hAAAA_AAAA, 1'b1);
    add_point(-32'sh0003_0000, 32'sh0004_0000, 32'sd0, 16'sd12869, 32'h5555_5555, 1'b0);
    add_point(32'sd12345, 32'sd67890, -32'sd5000, -16'sd12868, 32'h0001_0000, 1'b1);
    add_point(32'sd0, 32'sd0, 32'sd0, -16'sd12869, 32'h0000_8000, 1'b0);
    add_point(32'sd100, 32'sd200, 32'sd300, 16'sd32767, 32'h1234_5678, 1'b1);
    add_point(-32'sd100, -32'sd200, -32'sd300, -16'sd32768, 32'h8765_4321, 1'b0);
    add_point(32'sd0, 32'sd0, 32'sh8000_0010, 16'sd20000, 32'h0, 1'b0);
    add_point(32'sh7FFF_FFF0, 32'sh8000_0010, 32'sh7FFF_FFF0, -16'sd20000, 32'hFFFF_0000, 1'b1);
    add_point(32'sh8000_0010, 32'sh7FFF_FFF0, 32'sd0, 16'sd17157, 32'h0000_FFFF, 1'b0);
    add_point(32'sd0, 32'sd0, 32'sd0, 16'sd1, 32'h0, 1'b1);
    add_point(32'sd0, 32'sd0, 32'sd0, -16'sd1, 32'h0, 1'b0);

    for (int ph = 0; ph < PHASES; ph++) begin
      idle_pct = (ph < 3) ? 12 : ((ph < 6) ? 50 : 0);
      if (ph > 0) begin
        wait_idle();
        case (ph)
          1: begin hdg = ANGLE_PI; pit = -ANGLE_PI; word = 32'hFF_FFFF; end
          2: begin hdg = -ANGLE_PI; pit = ANGLE_PI; word = 32'h0; end
          3: begin hdg = 0; pit = 0; word = 32'h1; end
          4: begin hdg = 32767; pit = -32768; word = 32'hFF_FFFF; end
          5: begin
            hdg = $urandom_range(0, ANGLE_2PI) - ANGLE_PI;
            pit = $urandom_range(0, ANGLE_2PI) - ANGLE_PI;
            word = $urandom_range(0, 32'hFF_FFFF);
          end
          6: begin hdg = $urandom; pit = $urandom; word = $urandom; end
          default: begin
            hdg = ANGLE_PI2;
            pit = -ANGLE_PI2;
            word = $urandom_range(0, 32'h3F_FFFF);
          end
        endcase
        write_reg(REG_VIEW_DISTANCE, word[23:0]);
        word = $urandom;
        word[15:0] = hdg[15:0];
        write_reg(REG_VIEW_HEADING, word[23:0]);
        // unmapped index: must leave every register alone
        if (ph == 1) write_reg(REG_NONE, CFG_DATA_W'($urandom));
        word = $urandom;
        word[15:0] = pit[15:0];
        write_reg(REG_VIEW_PITCH, word[23:0]);
      end
      repeat (PHASE_POINTS)
        add_point(rand_pos(), rand_pos(), rand_pos(), rand_yaw(), $urandom,
                  1'($urandom_range(0, 1)));
    end

    wait_idle();
    repeat (LATENCY + 4) @(negedge clk);
    if (expected_poses.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_poses.size()));
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // watchdog
  initial begin
    #400000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

/* sim.f */
hdl/cfop_pkg.sv
hdl/camera_follow_offset_pose.sv
hdl/cfop_checker.sv
tb/sv/camera_follow_offset_pose_tb.sv
